/* rtl/core/cppm_pkg.sv */
// ---------------------------------------------------------------------------
// cppm_pkg
// Shared types and constants for the convex polygon pixel mask.
// ---------------------------------------------------------------------------
package cppm_pkg;

   // default depth of the edge table
   localparam int MAX_EDGES_DEF = 32;

   // field widths
   localparam int CRD_W  = 13;   // signed vertex / reference coordinate
   localparam int PIX_W  = 12;   // unsigned pixel column / row
   localparam int COL_W  = 8;    // color component
   localparam int OP_W   = 2;
   localparam int A_W    = 14;   // edge a and b coefficients
   localparam int C_W    = 28;   // edge c coefficient
   localparam int PROD_W = 27;   // 13 x 14 signed product
   localparam int SUM_W  = 30;   // line value
   localparam int CSR_IDX_W = 2;

   // depth of the pixel queue between front and back
   localparam int FIFO_DEPTH = 2;

   // item opcodes
   localparam logic [OP_W-1:0] OP_FIRST = 2'd0;
   localparam logic [OP_W-1:0] OP_NEXT  = 2'd1;
   localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_INSIDE = 2'd2;

   // pixel request held in the queue
   typedef struct packed {
      logic [PIX_W-1:0] col;
      logic [PIX_W-1:0] row;
      logic [COL_W-1:0] blue;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] red;
   } pixel_type;

   // one edge line a*x + b*y + c
   typedef struct packed {
      logic [A_W-1:0] a;
      logic [A_W-1:0] b;
      logic [C_W-1:0] c;
   } edge_type;

   // edge table write from front to back
   typedef struct packed {
      logic     vld;
      edge_type line;
   } edge_wr_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [CRD_W-1:0] ref_x;
      logic [CRD_W-1:0] ref_y;
      logic             mask_inside;
   } cfg_type;

endpackage

/* rtl/core/cppm_front.sv */
// ---------------------------------------------------------------------------
// cppm_front
// Accepts requests, tracks the vertex list, builds edge lines and queues
// pixel requests for the back end.
// ---------------------------------------------------------------------------
module cppm_front #(
   parameter int MAX_EDGES = cppm_pkg::MAX_EDGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cppm_pkg::OP_W-1:0]            req_op,
   input  logic [cppm_pkg::CRD_W-1:0]           req_vertex_x,
   input  logic [cppm_pkg::CRD_W-1:0]           req_vertex_y,
   input  logic [cppm_pkg::PIX_W-1:0]           req_pixel_col,
   input  logic [cppm_pkg::PIX_W-1:0]           req_pixel_row,
   input  logic [cppm_pkg::COL_W-1:0]           req_blue_in,
   input  logic [cppm_pkg::COL_W-1:0]           req_green_in,
   input  logic [cppm_pkg::COL_W-1:0]           req_red_in,
   input  logic                                 fifo_full,
   input  logic                                 fifo_empty,
   input  logic                                 back_busy,
   output logic                                 fifo_push,
   output cppm_pkg::pixel_type                  fifo_wdata,
   output cppm_pkg::edge_wr_type                edge_wr,
   output logic [$clog2(MAX_EDGES)-1:0]         edge_wr_addr,
   output logic [$clog2(MAX_EDGES+1)-1:0]       edge_count
);
   import cppm_pkg::*;

   localparam int IDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   logic                    is_vertex;
   logic                    is_pixel;
   logic                    accept;
   logic                    start_list;
   logic                    add_edge;
   logic signed [A_W-1:0]   dx;
   logic signed [A_W-1:0]   dy;

   logic                    have_vertex_ff;
   logic [CRD_W-1:0]        prev_x_ff;
   logic [CRD_W-1:0]        prev_y_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    wr_vld_ff;
   logic [IDX_W-1:0]        wr_addr_ff;
   logic [A_W-1:0]          a_ff;
   logic [A_W-1:0]          b_ff;
   logic signed [PROD_W-1:0] p1_ff;
   logic signed [PROD_W-1:0] p2_ff;

   // classify the request and decide whether to hold it
   always_comb begin
      is_vertex = (req_op == OP_FIRST) || (req_op == OP_NEXT);
      is_pixel  = (req_op == OP_PIXEL);
      req_stall = (is_pixel && fifo_full) ||
                  (is_vertex && (!fifo_empty || back_busy));
      accept     = req_valid && !req_stall;
      start_list = accept && ((req_op == OP_FIRST) ||
                              ((req_op == OP_NEXT) && !have_vertex_ff));
      add_edge   = accept && (req_op == OP_NEXT) && have_vertex_ff &&
                   (count_ff < CNT_W'(MAX_EDGES));
      dx = $signed({req_vertex_x[CRD_W-1], req_vertex_x}) -
           $signed({prev_x_ff[CRD_W-1], prev_x_ff});
      dy = $signed({req_vertex_y[CRD_W-1], req_vertex_y}) -
           $signed({prev_y_ff[CRD_W-1], prev_y_ff});
   end

   // vertex list control
   always_ff @(posedge clock) begin
      if (reset) begin
         have_vertex_ff <= 1'b0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         count_ff       <= '0;
         wr_vld_ff      <= 1'b0;
      end else begin
         wr_vld_ff <= add_edge;
         if (start_list) begin
            have_vertex_ff <= 1'b1;
            count_ff       <= '0;
         end else if (add_edge) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (accept && is_vertex) begin
            prev_x_ff <= req_vertex_x;
            prev_y_ff <= req_vertex_y;
         end
      end
   end

   // register edge coefficients and the two products of c
   always_ff @(posedge clock) begin
      if (add_edge) begin
         wr_addr_ff <= count_ff[IDX_W-1:0];
         a_ff       <= dy;
         b_ff       <= -dx;
         p1_ff      <= $signed(prev_y_ff) * dx;
         p2_ff      <= $signed(prev_x_ff) * dy;
      end
   end

   // finish c and hand the edge to the table
   always_comb begin
      edge_wr.vld    = wr_vld_ff;
      edge_wr.line.a = a_ff;
      edge_wr.line.b = b_ff;
      edge_wr.line.c = {p1_ff[PROD_W-1], p1_ff} - {p2_ff[PROD_W-1], p2_ff};
      edge_wr_addr   = wr_addr_ff;
      edge_count     = count_ff;
   end

   // queue pixel requests
   always_comb begin
      fifo_push        = accept && is_pixel;
      fifo_wdata.col   = req_pixel_col;
      fifo_wdata.row   = req_pixel_row;
      fifo_wdata.blue  = req_blue_in;
      fifo_wdata.green = req_green_in;
      fifo_wdata.red   = req_red_in;
   end

endmodule

/* rtl/core/cppm_fifo.sv */
// ---------------------------------------------------------------------------
// cppm_fifo
// Short pixel queue between the front and back ends.
// ---------------------------------------------------------------------------
module cppm_fifo #(
   parameter int DEPTH = cppm_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cppm_pkg::pixel_type push_data,
   input  logic                pop,
   output cppm_pkg::pixel_type pop_data,
   output logic                empty,
   output logic                full
);
   import cppm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pixel_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/cppm_back.sv */
// ---------------------------------------------------------------------------
// cppm_back
// Holds the edge table and tests each queued pixel against the stored
// edges one per cycle, then presents the masked color.
// ---------------------------------------------------------------------------
module cppm_back #(
   parameter int MAX_EDGES = cppm_pkg::MAX_EDGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cppm_pkg::cfg_type                    cfg,
   input  cppm_pkg::edge_wr_type                edge_wr,
   input  logic [$clog2(MAX_EDGES)-1:0]         edge_wr_addr,
   input  logic [$clog2(MAX_EDGES+1)-1:0]       edge_count,
   input  logic                                 fifo_empty,
   input  cppm_pkg::pixel_type                  fifo_rdata,
   output logic                                 fifo_pop,
   output logic                                 back_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cppm_pkg::COL_W-1:0]           rsp_blue_out,
   output logic [cppm_pkg::COL_W-1:0]           rsp_green_out,
   output logic [cppm_pkg::COL_W-1:0]           rsp_red_out,
   output logic                                 rsp_outside
);
   import cppm_pkg::*;

   localparam int IDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                state_ff;
   edge_type                 mem [MAX_EDGES];
   edge_type                 rd_ff;
   pixel_type                pix_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         issue_ff;
   logic                     rd_vld_ff;
   logic                     mul_vld_ff;
   logic                     flag_ff;
   logic signed [PROD_W-1:0] pa_ff;
   logic signed [PROD_W-1:0] pb_ff;
   logic signed [PROD_W-1:0] ra_ff;
   logic signed [PROD_W-1:0] rb_ff;
   logic signed [C_W-1:0]    c_ff;
   logic                     rsp_valid_ff;
   logic [COL_W-1:0]         blue_ff;
   logic [COL_W-1:0]         green_ff;
   logic [COL_W-1:0]         red_ff;
   logic                     outside_ff;

   logic                     issue_en;
   logic                     out_free;
   logic                     rsp_load;
   logic                     masked;
   logic                     separated;
   logic signed [SUM_W-1:0]  lp;
   logic signed [SUM_W-1:0]  lr;
   logic signed [CRD_W-1:0]  px_s;
   logic signed [CRD_W-1:0]  py_s;

   // issue, sum and output control
   always_comb begin
      issue_en  = (state_ff == ST_RUN) && (issue_ff < cnt_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
      rsp_load  = (state_ff == ST_DONE) && out_free;
      fifo_pop  = (state_ff == ST_IDLE) && !fifo_empty;
      back_busy = (state_ff != ST_IDLE);
      px_s      = $signed({1'b0, pix_ff.col});
      py_s      = $signed({1'b0, pix_ff.row});
      lp = $signed({{(SUM_W-PROD_W){pa_ff[PROD_W-1]}}, pa_ff}) +
           $signed({{(SUM_W-PROD_W){pb_ff[PROD_W-1]}}, pb_ff}) +
           $signed({{(SUM_W-C_W){c_ff[C_W-1]}}, c_ff});
      lr = $signed({{(SUM_W-PROD_W){ra_ff[PROD_W-1]}}, ra_ff}) +
           $signed({{(SUM_W-PROD_W){rb_ff[PROD_W-1]}}, rb_ff}) +
           $signed({{(SUM_W-C_W){c_ff[C_W-1]}}, c_ff});
      // strictly opposite signs, a zero on either side never separates
      separated = ((lp < 0) && (lr > 0)) || ((lp > 0) && (lr < 0));
      masked    = cfg.mask_inside ? !flag_ff : flag_ff;
   end

   // edge table: one write port from the front, one read port here
   always_ff @(posedge clock) begin
      if (edge_wr.vld) begin
         mem[edge_wr_addr] <= edge_wr.line;
      end
      if (issue_en) begin
         rd_ff <= mem[issue_ff[IDX_W-1:0]];
      end
   end

   // multiply the edge by the pixel and by the reference point
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         pa_ff <= px_s * $signed(rd_ff.a);
         pb_ff <= py_s * $signed(rd_ff.b);
         ra_ff <= $signed(cfg.ref_x) * $signed(rd_ff.a);
         rb_ff <= $signed(cfg.ref_y) * $signed(rd_ff.b);
         c_ff  <= $signed(rd_ff.c);
      end
   end

   // sequence one pixel at a time and hold the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= issue_en;
         mul_vld_ff   <= rd_vld_ff;
         // load a new result or hold a stalled one
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         case (state_ff)
            ST_IDLE: begin
               if (!fifo_empty) begin
                  pix_ff   <= fifo_rdata;
                  cnt_ff   <= edge_count;
                  issue_ff <= '0;
                  flag_ff  <= 1'b0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue_en) begin
                  issue_ff <= issue_ff + CNT_W'(1);
               end
               if (mul_vld_ff && separated) begin
                  flag_ff <= 1'b1;
               end
               if (!issue_en && !rd_vld_ff && !mul_vld_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  blue_ff      <= masked ? '0 : pix_ff.blue;
                  green_ff     <= masked ? '0 : pix_ff.green;
                  red_ff       <= masked ? '0 : pix_ff.red;
                  outside_ff   <= flag_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_green_out = green_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_outside   = outside_ff;

endmodule

/* rtl/core/convex_polygon_pixel_mask.sv */
// ---------------------------------------------------------------------------
// convex_polygon_pixel_mask
// Convex polygon pixel mask: vertex requests build an edge table, pixel
// requests are tested against every edge and passed or blackened.
// ---------------------------------------------------------------------------
// A vertex request's edge line is registered in the front (coefficients and
// the two products of c), then c is finished and the line is written to the
// table. A pixel request goes into a two-entry queue and the back end tests
// it against the stored edges through a single read port of the edge table,
// one edge per cycle; it takes the next pixel only once the result of the
// last one is loaded into the output register. A vertex request is held
// while any pixel is queued or under test, so that each pixel sees exactly
// the edges defined before it. Results sit in an output register, and the
// front keeps queuing pixels while one waits. csr_ready is always high;
// write the registers only while no pixel is in flight.
module convex_polygon_pixel_mask #(
   parameter int MAX_EDGES = cppm_pkg::MAX_EDGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cppm_pkg::OP_W-1:0]     req_op,
   input  logic [cppm_pkg::CRD_W-1:0]    req_vertex_x,
   input  logic [cppm_pkg::CRD_W-1:0]    req_vertex_y,
   input  logic [cppm_pkg::PIX_W-1:0]    req_pixel_col,
   input  logic [cppm_pkg::PIX_W-1:0]    req_pixel_row,
   input  logic [cppm_pkg::COL_W-1:0]    req_blue_in,
   input  logic [cppm_pkg::COL_W-1:0]    req_green_in,
   input  logic [cppm_pkg::COL_W-1:0]    req_red_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cppm_pkg::COL_W-1:0]    rsp_blue_out,
   output logic [cppm_pkg::COL_W-1:0]    rsp_green_out,
   output logic [cppm_pkg::COL_W-1:0]    rsp_red_out,
   output logic                          rsp_outside,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cppm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cppm_pkg::CRD_W-1:0]    csr_wdata
);
   import cppm_pkg::*;

   localparam int IDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   logic [CRD_W-1:0] ref_x_reg_ff;
   logic [CRD_W-1:0] ref_y_reg_ff;
   logic             mask_inside_ff;
   cfg_type          cfg;

   logic             fifo_push;
   logic             fifo_pop;
   logic             fifo_empty;
   logic             fifo_full;
   pixel_type        fifo_wdata;
   pixel_type        fifo_rdata;
   edge_wr_type      edge_wr;
   logic [IDX_W-1:0] edge_wr_addr;
   logic [CNT_W-1:0] edge_count;
   logic             back_busy;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_reg_ff   <= '0;
         ref_y_reg_ff   <= '0;
         mask_inside_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REF_X: begin
               ref_x_reg_ff <= csr_wdata;
            end
            CSR_REF_Y: begin
               ref_y_reg_ff <= csr_wdata;
            end
            CSR_MASK_INSIDE: begin
               mask_inside_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.ref_x       = ref_x_reg_ff;
      cfg.ref_y       = ref_y_reg_ff;
      cfg.mask_inside = mask_inside_ff;
   end

   cppm_front #(
      .MAX_EDGES (MAX_EDGES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_vertex_x  (req_vertex_x),
      .req_vertex_y  (req_vertex_y),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .fifo_full     (fifo_full),
      .fifo_empty    (fifo_empty),
      .back_busy     (back_busy),
      .fifo_push     (fifo_push),
      .fifo_wdata    (fifo_wdata),
      .edge_wr       (edge_wr),
      .edge_wr_addr  (edge_wr_addr),
      .edge_count    (edge_count)
   );

   cppm_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wdata),
      .pop       (fifo_pop),
      .pop_data  (fifo_rdata),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   cppm_back #(
      .MAX_EDGES (MAX_EDGES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .edge_wr       (edge_wr),
      .edge_wr_addr  (edge_wr_addr),
      .edge_count    (edge_count),
      .fifo_empty    (fifo_empty),
      .fifo_rdata    (fifo_rdata),
      .fifo_pop      (fifo_pop),
      .back_busy     (back_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_outside   (rsp_outside)
   );

endmodule

/* rtl/core/cppm_checker.sv */
// ---------------------------------------------------------------------------
// cppm_checker
// Port-level checks for the convex polygon pixel mask, bound to the top.
// ---------------------------------------------------------------------------
module cppm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [cppm_pkg::OP_W-1:0]      req_op,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [cppm_pkg::COL_W-1:0]     rsp_blue_out,
   input logic [cppm_pkg::COL_W-1:0]     rsp_green_out,
   input logic [cppm_pkg::COL_W-1:0]     rsp_red_out,
   input logic                           rsp_outside,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [cppm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [cppm_pkg::CRD_W-1:0]     csr_wdata
);
   import cppm_pkg::*;

   logic [3:0] pend_ff;
   logic       mask_ff;
   logic       pix_acc;
   logic       rsp_acc;
   logic       masked;

   assign pix_acc = req_valid && !req_stall && (req_op == OP_PIXEL);
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign masked  = mask_ff ? !rsp_outside : rsp_outside;

   // track pixels in flight and the mask mode
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         mask_ff <= 1'b0;
      end else begin
         if (pix_acc && !rsp_acc) begin
            pend_ff <= pend_ff + 4'd1;
         end else if (rsp_acc && !pix_acc) begin
            pend_ff <= pend_ff - 4'd1;
         end
         if (csr_valid && csr_ready && (csr_index == CSR_MASK_INSIDE)) begin
            mask_ff <= csr_wdata[0];
         end
      end
   end

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // every result answers a pixel request
   a_rsp_has_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 4'd0))
      else $error("result without a pending pixel");

   // masked pixels come out black
   a_masked_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && masked) |->
         (rsp_blue_out == '0) && (rsp_green_out == '0) && (rsp_red_out == '0))
      else $error("masked pixel not black");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_outside) &&
         $stable(rsp_blue_out) && $stable(rsp_green_out) && $stable(rsp_red_out))
      else $error("stalled result changed");

endmodule

bind convex_polygon_pixel_mask cppm_checker u_cppm_checker (.*);
